FILE: hdl/wfr_pkg.sv
// Shared types and constants for the word frame receiver.
// No dependencies; imported by word_frame_receiver_unit and wfr_checker.
`timescale 1ns / 1ps

package wfr_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_RECEIVE = 2'd0,
      OP_POLL    = 2'd1,
      OP_READ    = 2'd2,
      OP_RELEASE = 2'd3
   } op_type;

   // frame events reported with a response
   typedef enum logic [2:0] {
      EV_NONE    = 3'd0,
      EV_GOOD    = 3'd1,
      EV_CHECK   = 3'd2,
      EV_TIMEOUT = 3'd3,
      EV_LENGTH  = 3'd4
   } event_type;

   // receiver phase
   typedef enum logic [1:0] {
      PH_HUNT     = 2'd0,
      PH_TYPE_LEN = 2'd1,
      PH_PAYLOAD  = 2'd2
   } phase_type;

   // configuration register indexes
   localparam logic [7:0] CSR_SYNC_WORD     = 8'd0;
   localparam logic [7:0] CSR_TIMEOUT_LIMIT = 8'd1;

   localparam logic [31:0] SYNC_WORD_RESET     = 32'h1bdf9bdf;
   localparam logic [7:0]  TIMEOUT_LIMIT_RESET = 8'd2;

   // sync, type/length and checksum words around the payload
   localparam int unsigned FRAME_OVERHEAD = 3;
   localparam logic [15:0] TICK_MAX       = 16'hffff;

   // response fields other than the buffered read data
   typedef struct packed {
      logic [7:0] command_type;
      logic [9:0] word_count;
      phase_type  phase;
      logic       frame_ready;
      event_type  frame_event;
      logic       accepted;
   } rsp_info_type;

endpackage

FILE: hdl/word_frame_receiver_unit.sv
// Word frame receiver top level: frame assembly, buffer and response path.
// Depends on wfr_pkg.
`timescale 1ns / 1ps

// Takes one request per cycle and returns one response per request, in order.
// A request goes through the frame state logic in the cycle it is accepted;
// the buffer read for a read request and the response fields are registered
// at that same edge, the fields into a hold stage. The hold stage sits between
// the state logic and the response register, so a new request is taken while
// a finished response waits; requests stall only once both are full. The
// buffer is a single-port-write, single-port-read memory of BUFFER_DEPTH
// words, written once per stored word. A frame is the sync word, a
// type/length word (length in bits 15..0), the payload and a checksum word
// chosen so that all words XOR to zero. A good frame is held and further
// words are refused until a release request. Configuration writes are taken
// at any time and are meant for when the block is idle.
module word_frame_receiver_unit #(
   parameter int BUFFER_DEPTH = 512
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // data_word[31:0], read_index[40:32], zero pad
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // accepted[0], frame_event[3:1], frame_ready[4],
                                    // phase[6:5], word_count[16:7],
                                    // command_type[24:17], read_data[56:25], zero pad
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import wfr_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam int WW = (CW > 10) ? CW : 10;
   localparam logic [CW-1:0] DEPTH_C   = CW'(BUFFER_DEPTH);
   localparam logic [16:0]   DEPTH_LEN = 17'(BUFFER_DEPTH);
   localparam logic [16:0]   OVH_LEN   = 17'(FRAME_OVERHEAD);
   localparam logic [CW:0]   OVH_END   = (CW + 1)'(FRAME_OVERHEAD - 1);

   // configuration registers
   logic [31:0] sync_word_ff;
   logic [7:0]  timeout_limit_ff;

   // frame state
   phase_type   phase_ff, phase_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] payload_ff, payload_in;
   logic [31:0] xor_ff, xor_in;
   logic [15:0] tick_ff, tick_in;
   logic        held_ff, held_in;
   logic [7:0]  ctype_ff, ctype_in;

   // buffer
   logic [31:0]   mem [BUFFER_DEPTH];
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic [31:0]   mem_rd_ff;

   // request decode
   logic        accept;
   op_type      op;
   logic [31:0] word;
   logic [WW-1:0] idx_ext;
   logic [16:0] len_total;
   logic        put_ok;
   logic        acc;
   event_type   ev;
   logic        rd_ok;
   rsp_info_type info;

   // hold stage and response register
   logic         s1_valid_ff;
   rsp_info_type s1_info_ff;
   logic         s1_rd_ok_ff;
   logic         s1_move;
   logic         rsp_valid_ff;
   logic [63:0]  rsp_data_ff;

   assign accept    = req_tvalid & req_tready;
   assign op        = op_type'(req_tuser);
   assign word      = req_tdata[31:0];
   assign idx_ext   = WW'(req_tdata[40:32]);
   assign rd_addr   = idx_ext[AW-1:0];
   assign len_total = {1'b0, word[15:0]} + OVH_LEN;
   assign put_ok    = (count_ff != DEPTH_C);
   assign csr_ready = 1'b1;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_word_ff     <= SYNC_WORD_RESET;
         timeout_limit_ff <= TIMEOUT_LIMIT_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_SYNC_WORD)
            sync_word_ff <= csr_wdata;
         else if (csr_index == CSR_TIMEOUT_LIMIT)
            timeout_limit_ff <= csr_wdata[7:0];
      end
   end

   // next frame state
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      payload_in = payload_ff;
      xor_in     = xor_ff;
      tick_in    = tick_ff;
      held_in    = held_ff;
      ctype_in   = ctype_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      acc        = 1'b0;
      ev         = EV_NONE;
      rd_ok      = 1'b0;
      if (accept) begin
         case (op)
            OP_RECEIVE: begin
               if (!held_ff) begin
                  acc = 1'b1;
                  case (phase_ff)
                     PH_HUNT: begin
                        count_in = '0;
                        xor_in   = '0;
                        tick_in  = '0;
                        if (word == sync_word_ff) begin
                           wr_en    = 1'b1;
                           wr_addr  = '0;
                           count_in = CW'(1);
                           xor_in   = word;
                           phase_in = PH_TYPE_LEN;
                        end
                     end
                     PH_TYPE_LEN: begin
                        if (tick_ff < 16'(timeout_limit_ff)) begin
                           if (len_total > DEPTH_LEN) begin
                              count_in = '0;
                              xor_in   = '0;
                              tick_in  = '0;
                              phase_in = PH_HUNT;
                              ev       = EV_LENGTH;
                           end else begin
                              wr_en      = put_ok;
                              count_in   = put_ok ? count_ff + CW'(1) : count_ff;
                              xor_in     = xor_ff ^ word;
                              ctype_in   = word[23:16];
                              payload_in = CW'(word[15:0]);
                              phase_in   = PH_PAYLOAD;
                              tick_in    = '0;
                           end
                        end else begin
                           count_in = '0;
                           xor_in   = '0;
                           tick_in  = '0;
                           phase_in = PH_HUNT;
                           ev       = EV_TIMEOUT;
                        end
                     end
                     PH_PAYLOAD: begin
                        if (tick_ff > 16'(timeout_limit_ff)) begin
                           count_in = '0;
                           xor_in   = '0;
                           tick_in  = '0;
                           phase_in = PH_HUNT;
                           ev       = EV_TIMEOUT;
                        end else begin
                           wr_en    = put_ok;
                           count_in = put_ok ? count_ff + CW'(1) : count_ff;
                           xor_in   = xor_ff ^ word;
                           // checksum word closes the frame
                           if (!(((CW + 1)'(payload_ff) + OVH_END) >
                                 (CW + 1)'(count_ff))) begin
                              if ((xor_ff ^ word) == 32'd0) begin
                                 held_in  = 1'b1;
                                 ev       = EV_GOOD;
                                 phase_in = PH_HUNT;
                                 tick_in  = '0;
                              end else begin
                                 count_in = '0;
                                 xor_in   = '0;
                                 tick_in  = '0;
                                 phase_in = PH_HUNT;
                                 ev       = EV_CHECK;
                              end
                           end
                        end
                     end
                     default: begin
                        count_in = '0;
                        xor_in   = '0;
                        tick_in  = '0;
                        phase_in = PH_HUNT;
                     end
                  endcase
               end
            end
            OP_POLL: begin
               if (!held_ff && (phase_ff == PH_PAYLOAD) && (tick_ff != TICK_MAX))
                  tick_in = tick_ff + 16'd1;
            end
            OP_READ: begin
               rd_ok = (idx_ext < WW'(count_ff));
            end
            OP_RELEASE: begin
               if (held_ff) begin
                  held_in  = 1'b0;
                  count_in = '0;
                  xor_in   = '0;
               end
            end
            default: begin
               held_in = held_ff;
            end
         endcase
      end
   end

   // response fields from the updated state
   always_comb begin
      info.accepted     = acc;
      info.frame_event  = ev;
      info.frame_ready  = held_in;
      info.phase        = phase_in;
      info.word_count   = WW'(count_in) >= WW'(1) ? 10'(WW'(count_in)) : 10'd0;
      info.command_type = (WW'(count_in) >= WW'(2)) ? ctype_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         count_ff <= '0;
         xor_ff   <= '0;
         tick_ff  <= '0;
         held_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         xor_ff   <= xor_in;
         tick_ff  <= tick_in;
         held_ff  <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      ctype_ff   <= ctype_in;
   end

   // frame buffer, registered read
   always_ff @(posedge clock) begin
      if (wr_en)
         mem[wr_addr] <= word;
      if (accept)
         mem_rd_ff <= mem[rd_addr];
   end

   // hold stage, then response register
   assign s1_move    = s1_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready = ~s1_valid_ff | s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept)
            s1_valid_ff <= 1'b1;
         else if (s1_move)
            s1_valid_ff <= 1'b0;
         if (s1_move)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff  <= info;
         s1_rd_ok_ff <= rd_ok;
      end
      if (s1_move)
         rsp_data_ff <= {7'd0, (s1_rd_ok_ff ? mem_rd_ff : 32'd0), s1_info_ff};
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: hdl/wfr_checker.sv
// Port-level checks on the word frame receiver response stream.
// Depends on wfr_pkg; bound to word_frame_receiver_unit.
`timescale 1ns / 1ps

module wfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata
);
   import wfr_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // reset empties the response path
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a held frame leaves the receiver hunting for sync
   a_held_hunt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4] |-> rsp_tdata[6:5] == PH_HUNT)
      else $error("frame held outside hunting phase");

   // a frame event comes only with a word that was taken
   a_event_accepted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:1] != EV_NONE) |-> rsp_tdata[0])
      else $error("frame event on a refused or non-receive request");

   // a good frame is reported as held
   a_good_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[3:1] == EV_GOOD) |-> rsp_tdata[4])
      else $error("good frame not held");

endmodule

bind word_frame_receiver_unit wfr_checker u_wfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
